/* rtl/rc5_64_pkg.sv */
// shared constants, types and rotate helpers for the rc5 64-bit block cipher
package rc5_64_pkg;

	localparam int WORD_W = 64;
	localparam int SHIFT_W = 6;
	localparam int ROUND_COUNT_DEF = 18;
	localparam int KEY_WORDS_DEF = 16;
	localparam int MIX_ROT = 3;

	localparam logic [WORD_W-1:0] MAGIC_P = 64'hb7e151628aed2a6b;
	localparam logic [WORD_W-1:0] MAGIC_Q = 64'h9e3779b97f4a7c15;

	// request opcodes
	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_EXPAND = 2'd1;
	localparam logic [1:0] OP_ENCRYPT = 2'd2;
	localparam logic [1:0] OP_DECRYPT = 2'd3;

	// control of the shared half-round unit
	typedef struct packed {
		logic enc;
		logic white;
	} rc5_64_ctl_t;

	function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
			input logic [SHIFT_W-1:0] sh);
		logic [2*WORD_W-1:0] tmp;
		tmp = {x, x} << sh;
		return tmp[2*WORD_W-1:WORD_W];
	endfunction

	function automatic logic [WORD_W-1:0] rotr64(input logic [WORD_W-1:0] x,
			input logic [SHIFT_W-1:0] sh);
		logic [2*WORD_W-1:0] tmp;
		tmp = {x, x} >> sh;
		return tmp[WORD_W-1:0];
	endfunction

endpackage

/* rtl/rc5_64_if.sv */
// request and response channel interfaces of the rc5 64-bit block cipher
interface rc5_64_req_if;
	logic valid;
	logic ready;
	logic [1:0] opcode;
	logic [3:0] key_index;
	logic [63:0] block_a;
	logic [63:0] block_b;

	modport source(output valid, opcode, key_index, block_a, block_b, input ready);
	modport sink(input valid, opcode, key_index, block_a, block_b, output ready);
endinterface

interface rc5_64_rsp_if;
	logic valid;
	logic ready;
	logic [63:0] out_a;
	logic [63:0] out_b;
	logic status;

	modport source(output valid, out_a, out_b, status, input ready);
	modport sink(input valid, out_a, out_b, status, output ready);
endinterface

/* rtl/rc5_64_ram.sv */
// generic single-write, single-read ram with registered read data
module rc5_64_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/rc5_64_round.sv */
// shared half-round unit: whitening add/sub, encrypt and decrypt half-rounds
module rc5_64_round import rc5_64_pkg::*; (
	input  rc5_64_ctl_t       ctl,
	input  logic [WORD_W-1:0] x,
	input  logic [WORD_W-1:0] y,
	input  logic [WORD_W-1:0] s,
	output logic [WORD_W-1:0] res
);

	logic [SHIFT_W-1:0] sh;

	assign sh = y[SHIFT_W-1:0];

	// one word update per use
	always_comb begin
		if (ctl.white) begin
			res = ctl.enc ? (x + s) : (x - s);
		end else if (ctl.enc) begin
			res = rotl64(x ^ y, sh) + s;
		end else begin
			res = rotr64(x - s, sh) ^ y;
		end
	end

endmodule

/* rtl/rc5_64_block_cipher.sv */
// rc5 block cipher with 64-bit words: key load, key expansion, encrypt, decrypt
//
// one request channel (req) carries opcode, key_index, block_a and block_b;
// one response channel (rsp) returns out_a, out_b and status, one response
// per request, in order. valid/ready handshakes on both sides.
// load key: writes raw key word key_index (ignored past KEY_WORDS); the done
//   state then loads the response, and the next request waits for idle.
// expand: writes 2*(ROUND_COUNT+1) schedule words, one a cycle, then runs
//   3*max(schedule size, KEY_WORDS) mixing steps, each through a read, a
//   schedule update and a key word update state, then loads the response;
//   the block takes the next request only once it is back in idle.
// encrypt/decrypt: one half-round a cycle through a shared unit fed by the
//   single schedule ram read port: 2*ROUND_COUNT schedule reads, then the
//   last read data is applied and the done state loads the response register;
//   a new block is taken only once the block is back in idle.
// a cipher request before any expand answers from the done state with status 1.
// the block takes one request at a time; req.ready is high only when idle.
// a finished response waits in an output register while the next request
// is taken; if that register is still full, the block holds until it drains.
// reset clears the control state and the schedule-ready flag; key and
// schedule memories are not cleared.
module rc5_64_block_cipher import rc5_64_pkg::*; #(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF,
	parameter int KEY_WORDS = KEY_WORDS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	rc5_64_req_if.sink       req,
	rc5_64_rsp_if.source     rsp
);

	localparam int SCHED_WORDS = 2 * (ROUND_COUNT + 1);
	localparam int S_AW = $clog2(SCHED_WORDS);
	localparam int KW_AW = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
	localparam int MIX_STEPS = 3 * ((SCHED_WORDS > KEY_WORDS) ? SCHED_WORDS : KEY_WORDS);
	localparam int K_W = $clog2(MIX_STEPS);
	localparam int LEFT_W = $clog2(2 * ROUND_COUNT + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INIT = 3'd1;
	localparam logic [2:0] ST_MIX_RD = 3'd2;
	localparam logic [2:0] ST_MIX_A = 3'd3;
	localparam logic [2:0] ST_MIX_B = 3'd4;
	localparam logic [2:0] ST_CIPH = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	logic [2:0] state_q;
	logic sched_rdy_q;
	logic ovalid_q;
	logic enc_q;
	logic first_q;
	logic vld_s1;
	logic [S_AW-1:0] addr_s1;
	logic [S_AW-1:0] addr_q;
	logic [LEFT_W-1:0] left_q;
	logic [S_AW-1:0] i_q;
	logic [KW_AW-1:0] j_q;
	logic [K_W-1:0] k_q;

	logic [WORD_W-1:0] a_q, b_q, ma_q, mb_q, init_q;
	logic [WORD_W-1:0] out_a_q, out_b_q;
	logic status_q, res_zero_q;
	logic out_st_q;

	logic acc;
	logic [5:0] idx_ext;
	logic load_ok;
	logic is_cipher;

	logic s_we, s_re;
	logic [S_AW-1:0] s_raddr;
	logic [WORD_W-1:0] s_wdata, s_rdata;
	logic raw_we, key_re, work_we;
	logic [WORD_W-1:0] raw_rdata, work_rdata;

	logic [WORD_W-1:0] mix_a_new, mix_ab, mix_kw, mix_b_new;
	rc5_64_ctl_t unit_ctl;
	logic [WORD_W-1:0] unit_x, unit_y, unit_res;
	logic [S_AW-1:0] i_next;
	logic [KW_AW-1:0] j_next;

	// request decode
	assign acc = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign idx_ext = 6'(req.key_index);
	assign load_ok = (idx_ext < 6'(KEY_WORDS));
	assign is_cipher = (req.opcode == OP_ENCRYPT) || (req.opcode == OP_DECRYPT);

	// index wrap for the mixing walk
	assign i_next = (i_q == S_AW'(SCHED_WORDS - 1)) ? '0 : i_q + S_AW'(1);
	assign j_next = (j_q == KW_AW'(KEY_WORDS - 1)) ? '0 : j_q + KW_AW'(1);

	// key mixing arithmetic
	assign mix_a_new = rotl64(s_rdata + ma_q + mb_q, SHIFT_W'(MIX_ROT));
	assign mix_ab = ma_q + mb_q;
	assign mix_kw = first_q ? raw_rdata : work_rdata;
	assign mix_b_new = rotl64(mix_kw + mix_ab, mix_ab[SHIFT_W-1:0]);

	// schedule ram ports
	assign s_we = (state_q == ST_INIT) || (state_q == ST_MIX_A);
	assign s_wdata = (state_q == ST_INIT) ? init_q : mix_a_new;
	assign s_re = (state_q == ST_MIX_RD) || ((state_q == ST_CIPH) && (left_q != '0));
	assign s_raddr = (state_q == ST_CIPH) ? addr_q : i_q;

	rc5_64_ram #(.WIDTH(WORD_W), .DEPTH(SCHED_WORDS)) u_sched_ram (
		.clk   (clk),
		.we    (s_we),
		.waddr (i_q),
		.wdata (s_wdata),
		.re    (s_re),
		.raddr (s_raddr),
		.rdata (s_rdata)
	);

	// raw key words, written by load requests only
	assign raw_we = acc && (req.opcode == OP_LOAD) && load_ok;
	assign key_re = (state_q == ST_MIX_RD);

	rc5_64_ram #(.WIDTH(WORD_W), .DEPTH(KEY_WORDS)) u_raw_ram (
		.clk   (clk),
		.we    (raw_we),
		.waddr (idx_ext[KW_AW-1:0]),
		.wdata (req.block_a),
		.re    (key_re),
		.raddr (j_q),
		.rdata (raw_rdata)
	);

	// working copy of the key, mixed during expansion
	assign work_we = (state_q == ST_MIX_B);

	rc5_64_ram #(.WIDTH(WORD_W), .DEPTH(KEY_WORDS)) u_work_ram (
		.clk   (clk),
		.we    (work_we),
		.waddr (j_q),
		.wdata (mix_b_new),
		.re    (key_re),
		.raddr (j_q),
		.rdata (work_rdata)
	);

	// half-round operands: odd schedule words update b, even ones update a
	assign unit_ctl.enc = enc_q;
	assign unit_ctl.white = (addr_s1[S_AW-1:1] == '0);
	assign unit_x = addr_s1[0] ? b_q : a_q;
	assign unit_y = addr_s1[0] ? a_q : b_q;

	rc5_64_round u_round (
		.ctl (unit_ctl),
		.x   (unit_x),
		.y   (unit_y),
		.s   (s_rdata),
		.res (unit_res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sched_rdy_q <= 1'b0;
			ovalid_q <= 1'b0;
			enc_q <= 1'b0;
			first_q <= 1'b0;
			vld_s1 <= 1'b0;
			addr_s1 <= '0;
			addr_q <= '0;
			left_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			// response taken and nothing new to load this cycle
			if (ovalid_q && rsp.ready && (state_q != ST_DONE)) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (acc) begin
						enc_q <= (req.opcode == OP_ENCRYPT);
						if (req.opcode == OP_EXPAND) begin
							i_q <= '0;
							state_q <= ST_INIT;
						end else if (is_cipher && sched_rdy_q) begin
							addr_q <= (req.opcode == OP_ENCRYPT) ? '0
								: S_AW'(SCHED_WORDS - 3);
							left_q <= LEFT_W'(2 * ROUND_COUNT);
							vld_s1 <= 1'b0;
							state_q <= ST_CIPH;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_INIT: begin
					if (i_q == S_AW'(SCHED_WORDS - 1)) begin
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						state_q <= ST_MIX_RD;
					end else begin
						i_q <= i_q + S_AW'(1);
					end
				end
				ST_MIX_RD: begin
					first_q <= (k_q < K_W'(KEY_WORDS));
					state_q <= ST_MIX_A;
				end
				ST_MIX_A: begin
					state_q <= ST_MIX_B;
				end
				ST_MIX_B: begin
					i_q <= i_next;
					j_q <= j_next;
					k_q <= k_q + K_W'(1);
					if (k_q == K_W'(MIX_STEPS - 1)) begin
						sched_rdy_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MIX_RD;
					end
				end
				ST_CIPH: begin
					if (left_q != '0) begin
						addr_q <= enc_q ? addr_q + S_AW'(1) : addr_q - S_AW'(1);
						left_q <= left_q - LEFT_W'(1);
						addr_s1 <= addr_q;
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
						if (vld_s1) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (!ovalid_q || rsp.ready) begin
						ovalid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (acc) begin
					a_q <= req.block_a;
					b_q <= req.block_b;
					status_q <= is_cipher && !sched_rdy_q;
					res_zero_q <= !(is_cipher && sched_rdy_q);
					ma_q <= '0;
					mb_q <= '0;
					init_q <= MAGIC_P;
				end
			end
			ST_INIT: begin
				init_q <= init_q + MAGIC_Q;
			end
			ST_MIX_A: begin
				ma_q <= mix_a_new;
			end
			ST_MIX_B: begin
				mb_q <= mix_b_new;
			end
			ST_CIPH: begin
				if (vld_s1) begin
					if (addr_s1[0]) begin
						b_q <= unit_res;
					end else begin
						a_q <= unit_res;
					end
				end
			end
			ST_DONE: begin
				if (!ovalid_q || rsp.ready) begin
					out_a_q <= res_zero_q ? '0 : a_q;
					out_b_q <= res_zero_q ? '0 : b_q;
					out_st_q <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

	// response register
	assign rsp.valid = ovalid_q;
	assign rsp.out_a = out_a_q;
	assign rsp.out_b = out_b_q;
	assign rsp.status = out_st_q;

`ifndef SYNTHESIS
	// the block is busy right after taking a request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while busy");

	// an error response carries zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status |-> (rsp.out_a == '0) && (rsp.out_b == '0))
		else $error("error response with nonzero data");

	// cipher rounds only run on an expanded schedule
	a_ciph_sched: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CIPH |-> sched_rdy_q)
		else $error("cipher without schedule");

	// schedule-ready only rises at the end of mixing
	a_rdy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sched_rdy_q) |-> $past(state_q) == ST_MIX_B)
		else $error("schedule ready set outside expansion");
`endif

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the rc5 64-bit block cipher: directed table, then random sessions
module tb_top;
	import rc5_64_pkg::*;

	localparam int ROUNDS = ROUND_COUNT_DEF;
	localparam int KEY_N = KEY_WORDS_DEF;
	localparam int SCHED_N = 2 * (ROUNDS + 1);
	localparam int MIX_N = 3 * (SCHED_N > KEY_N ? SCHED_N : KEY_N);
	localparam logic [63:0] ZERO = 64'h0;
	localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 400;

	typedef struct packed {
		logic [63:0] wa;
		logic [63:0] wb;
		logic st;
	} rsp_word_t;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] idx;
		logic [63:0] a;
		logic [63:0] b;
		logic typed;
		rsp_word_t want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	rc5_64_req_if req_ch();
	rc5_64_rsp_if rsp_ch();

	rc5_64_block_cipher DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// predictor state
	logic [63:0] key_tab [KEY_N];
	logic [63:0] sched_tab [SCHED_N];
	logic sched_ok;

	rsp_word_t rsp_due_q [$];
	int err_cnt;
	int tx_idle_pct;
	int rx_stall_pct;
	int rx_hold_left;

	// directed requests: cipher before expand, key extremes, expand, cipher extremes,
	// load after expand keeps the old schedule
	dir_row_t dir_tab [0:24] = '{
		'{OP_ENCRYPT, 4'd0, ONES, ZERO, 1'b1, '{ZERO, ZERO, 1'b1}},
		'{OP_DECRYPT, 4'd15, ZERO, ONES, 1'b1, '{ZERO, ZERO, 1'b1}},
		'{OP_LOAD, 4'd0, ZERO, ONES, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd1, 64'h0123456789abcdef, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd2, 64'hfedcba9876543210, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd3, 64'h8000000000000000, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd4, 64'h0000000000000001, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd5, 64'h5555555555555555, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd6, 64'haaaaaaaaaaaaaaaa, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd7, 64'h00ff00ff00ff00ff, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd8, 64'hff00ff00ff00ff00, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd9, 64'h0f0f0f0f0f0f0f0f, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd10, 64'hf0f0f0f0f0f0f0f0, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd11, 64'h1122334455667788, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd12, 64'h99aabbccddeeff00, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd13, 64'hdeadbeefcafef00d, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd14, 64'h7fffffffffffffff, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd15, ONES, ONES, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_EXPAND, 4'd7, ONES, ONES, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_ENCRYPT, 4'd0, ZERO, ZERO, 1'b0, '{ZERO, ZERO, 1'b0}},
		'{OP_ENCRYPT, 4'd15, ONES, ONES, 1'b0, '{ZERO, ZERO, 1'b0}},
		'{OP_DECRYPT, 4'd0, ZERO, ZERO, 1'b0, '{ZERO, ZERO, 1'b0}},
		'{OP_DECRYPT, 4'd15, ONES, ONES, 1'b0, '{ZERO, ZERO, 1'b0}},
		'{OP_LOAD, 4'd5, ONES, ZERO, 1'b1, '{ZERO, ZERO, 1'b0}},
		'{OP_ENCRYPT, 4'd9, 64'h0123456789abcdef, 64'h8000000000000001, 1'b0,
			'{ZERO, ZERO, 1'b0}}
	};

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// word rotates, amount taken mod 64
	function automatic logic [63:0] rot_left(input logic [63:0] x, input logic [63:0] n);
		int unsigned s;
		s = n[5:0];
		if (s == 0)
			return x;
		return (x << s) | (x >> (64 - s));
	endfunction

	function automatic logic [63:0] rot_right(input logic [63:0] x, input logic [63:0] n);
		int unsigned s;
		s = n[5:0];
		if (s == 0)
			return x;
		return (x >> s) | (x << (64 - s));
	endfunction

	// key schedule: magic fill, then mix a copy of the raw key into it
	function automatic void build_schedule();
		logic [63:0] kw [KEY_N];
		logic [63:0] x;
		logic [63:0] y;
		int i;
		int j;
		kw = key_tab;
		sched_tab[0] = MAGIC_P;
		for (int k = 1; k < SCHED_N; k++)
			sched_tab[k] = sched_tab[k-1] + MAGIC_Q;
		x = '0;
		y = '0;
		i = 0;
		j = 0;
		for (int k = 0; k < MIX_N; k++) begin
			sched_tab[i] = rot_left(sched_tab[i] + x + y, MIX_ROT);
			x = sched_tab[i];
			kw[j] = rot_left(kw[j] + x + y, x + y);
			y = kw[j];
			i = (i + 1) % SCHED_N;
			j = (j + 1) % KEY_N;
		end
		sched_ok = 1'b1;
	endfunction

	// response that one request produces, updating key and schedule state
	function automatic rsp_word_t rc5_apply(input logic [1:0] op, input logic [3:0] idx,
			input logic [63:0] a, input logic [63:0] b);
		rsp_word_t r;
		logic [63:0] x;
		logic [63:0] y;
		r = '0;
		x = a;
		y = b;
		case (op)
			OP_LOAD: begin
				if (idx < KEY_N)
					key_tab[idx] = a;
			end
			OP_EXPAND: begin
				build_schedule();
			end
			default: begin
				if (!sched_ok) begin
					r.st = 1'b1;
				end else if (op == OP_ENCRYPT) begin
					x = x + sched_tab[0];
					y = y + sched_tab[1];
					for (int k = 1; k < ROUNDS; k++) begin
						x = rot_left(x ^ y, y) + sched_tab[2*k];
						y = rot_left(x ^ y, x) + sched_tab[2*k+1];
					end
					r.wa = x;
					r.wb = y;
				end else begin
					for (int k = ROUNDS - 1; k > 0; k--) begin
						y = rot_right(y - sched_tab[2*k+1], x) ^ x;
						x = rot_right(x - sched_tab[2*k], y) ^ y;
					end
					r.wb = y - sched_tab[1];
					r.wa = x - sched_tab[0];
				end
			end
		endcase
		return r;
	endfunction

	// random word with extra weight on the extremes
	function automatic logic [63:0] pick_word();
		case ($urandom_range(7))
			0: return ZERO;
			1: return ONES;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// offer one request after a random idle stretch; record its response when taken
	task automatic send_req(input logic [1:0] op, input logic [3:0] idx,
			input logic [63:0] a, input logic [63:0] b, input logic typed,
			input rsp_word_t typed_rsp);
		rsp_word_t calc;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= op;
		req_ch.key_index <= idx;
		req_ch.block_a <= a;
		req_ch.block_b <= b;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		calc = rc5_apply(op, idx, a, b);
		rsp_due_q.push_back(typed ? typed_rsp : calc);
	endtask

	// drop valid and wait until every outstanding response has come back
	task automatic drain_all();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (rsp_due_q.size() != 0)
			@(posedge clk);
	endtask

	// response side: random stalls plus a counted long hold-off
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rsp_ch.ready <= 1'b0;
			rx_hold_left <= rx_hold_left - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// response checker
	always @(posedge clk) begin
		rsp_word_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (rsp_due_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected response a=%h b=%h status=%b", $time,
					rsp_ch.out_a, rsp_ch.out_b, rsp_ch.status);
			end else begin
				want = rsp_due_q.pop_front();
				if (rsp_ch.out_a !== want.wa) begin
					err_cnt++;
					$display("%0t: out_a expected %h actual %h", $time, want.wa, rsp_ch.out_a);
				end
				if (rsp_ch.out_b !== want.wb) begin
					err_cnt++;
					$display("%0t: out_b expected %h actual %h", $time, want.wb, rsp_ch.out_b);
				end
				if (rsp_ch.status !== want.st) begin
					err_cnt++;
					$display("%0t: status expected %b actual %b", $time, want.st,
						rsp_ch.status);
				end
			end
		end
	end

	// run limit
	initial begin
		#12_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// stimulus
	initial begin
		int n_load;
		int n_ciph;
		int sent;
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.opcode = OP_LOAD;
		req_ch.key_index = '0;
		req_ch.block_a = '0;
		req_ch.block_b = '0;
		rsp_ch.ready = 1'b0;
		sched_ok = 1'b0;
		err_cnt = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_left = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		for (int r = 0; r < 25; r++)
			send_req(dir_tab[r].op, dir_tab[r].idx, dir_tab[r].a, dir_tab[r].b,
				dir_tab[r].typed, dir_tab[r].want);
		drain_all();

		// random sessions: reload some key words, usually expand, then cipher requests
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 80; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 80; end
				default: begin tx_idle_pct = 10; rx_stall_pct = 10; end
			endcase
			// long receiver hold-off so the block backs up into the request side
			if (ph == 0)
				rx_hold_left = HOLD_CYCLES;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				n_load = $urandom_range(4);
				for (int k = 0; k < n_load; k++)
					send_req(OP_LOAD, 4'($urandom_range(15)), pick_word(), pick_word(),
						1'b0, '0);
				sent += n_load;
				if ($urandom_range(3) != 0) begin
					send_req(OP_EXPAND, 4'($urandom_range(15)), pick_word(), pick_word(),
						1'b0, '0);
					sent++;
				end
				n_ciph = $urandom_range(4, 16);
				for (int k = 0; k < n_ciph; k++)
					send_req($urandom_range(1) ? OP_ENCRYPT : OP_DECRYPT,
						4'($urandom_range(15)), pick_word(), pick_word(), 1'b0, '0);
				sent += n_ciph;
			end
			drain_all();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rc5_64_pkg.sv
rtl/rc5_64_if.sv
rtl/rc5_64_ram.sv
rtl/rc5_64_round.sv
rtl/rc5_64_block_cipher.sv
tb/tb_top.sv
